// ===== src/sida_pkg.sv =====
package sida_pkg;

   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 8;
   localparam int DIGITS      = 10;
   localparam int BCD_W       = 4 * DIGITS;
   localparam int IDX_W       = 4;
   localparam int STEP_W      = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CHAR_W-1:0]  CH_MINUS  = 8'd45;
   localparam logic [CHAR_W-1:0]  CH_ZERO   = 8'd48;
   localparam logic [STEP_W-1:0]  CONV_STEPS = 6'd32;

   // One classified request: sign and unsigned magnitude.
   typedef struct packed {
      logic               neg;
      logic [VALUE_W-1:0] mag;
   } entry_type;

endpackage

// ===== src/sida_if.sv =====
interface sida_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [sida_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sida_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sida_pkg::CHAR_W-1:0] character;
   logic                        last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== src/sida_front.sv =====
module sida_front (
   input  logic                clock,
   input  logic                reset,
   sida_req_if.sink            req_chan,
   output logic                push_valid,
   input  logic                push_ready,
   output sida_pkg::entry_type push_entry
);

   logic                valid_ff;
   logic                valid_in;
   sida_pkg::entry_type entry_ff;
   logic                take;

   assign req_chan.ready = !valid_ff || push_ready;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // The magnitude of the most negative value is exact as an unsigned word.
   always_ff @(posedge clock) begin
      if (take) begin
         entry_ff.neg <= req_chan.value[sida_pkg::VALUE_W-1];
         entry_ff.mag <= req_chan.value[sida_pkg::VALUE_W-1]
                         ? (sida_pkg::VALUE_W'(0) - req_chan.value)
                         : req_chan.value;
      end
   end

   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

endmodule

// ===== src/sida_fifo.sv =====
module sida_fifo #(
   parameter int DEPTH = sida_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   output logic                        push_ready,
   input  sida_pkg::entry_type         push_entry,
   output logic                        pop_valid,
   input  logic                        pop_ready,
   output sida_pkg::entry_type         pop_entry,
   output logic [$clog2(DEPTH+1)-1:0]  level
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   sida_pkg::entry_type store_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = store_ff[rd_ptr_ff];
   assign level      = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/sida_back.sv =====
module sida_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  sida_pkg::entry_type pop_entry,
   output logic                busy,
   sida_rsp_if.source          rsp_chan
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic [sida_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [sida_pkg::VALUE_W-1:0] bin_ff, bin_in;
   logic [sida_pkg::BCD_W-1:0]   bcd_ff, bcd_in;
   logic [sida_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic                         sign_ff, sign_in;
   logic                         out_valid_ff, out_valid_in;
   logic [sida_pkg::CHAR_W-1:0]  out_char_ff, out_char_in;
   logic                         out_last_ff, out_last_in;
   logic [sida_pkg::BCD_W-1:0]   bcd_adj;
   logic [sida_pkg::IDX_W-1:0]   top_idx;
   logic [3:0]                   cur_digit;
   logic                         out_free;

   assign pop_ready = (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign cur_digit = bcd_ff[{idx_ff, 2'b00} +: 4];

   // Double-dabble correction: every BCD digit of five or more gets three added.
   always_comb begin
      logic [3:0] d;
      for (int k = 0; k < sida_pkg::DIGITS; k++) begin
         d = bcd_ff[4*k +: 4];
         bcd_adj[4*k +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
      end
   end

   // Most significant nonzero digit; zero yields a single digit.
   always_comb begin
      top_idx = '0;
      for (int k = 0; k < sida_pkg::DIGITS; k++) begin
         if (bcd_ff[4*k +: 4] != 4'd0) begin
            top_idx = sida_pkg::IDX_W'(k);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      idx_in       = idx_ff;
      sign_in      = sign_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               bin_in   = pop_entry.mag;
               bcd_in   = '0;
               sign_in  = pop_entry.neg;
               step_in  = sida_pkg::CONV_STEPS;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (step_ff != '0) begin
               bcd_in  = {bcd_adj[sida_pkg::BCD_W-2:0], bin_ff[sida_pkg::VALUE_W-1]};
               bin_in  = {bin_ff[sida_pkg::VALUE_W-2:0], 1'b0};
               step_in = step_ff - 1'b1;
            end else begin
               idx_in   = top_idx;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (sign_ff) begin
                  out_char_in = sida_pkg::CH_MINUS;
                  out_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  out_char_in = sida_pkg::CH_ZERO + {4'd0, cur_digit};
                  out_last_in = (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      idx_ff      <= idx_in;
      sign_ff     <= sign_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.character = out_char_ff;
   assign rsp_chan.last      = out_last_ff;

endmodule

// ===== src/signed_int_to_decimal_ascii.sv =====
// Renders signed 32-bit integers as decimal ASCII text for a character display.
// Each request on req_chan carries one value; the block answers on rsp_chan with
// one character per response, most significant first: a '-' for negative values,
// then the digits with leading zeros dropped (a lone '0' for zero). The final
// character of each number has last set. Both channels move a request or a
// response at a clock edge where valid and ready are both high.
// A front stage registers the sign and magnitude and hands them through a short
// queue to the converter, so new requests are taken while earlier ones are still
// being converted or printed. The converter runs a double-dabble pass of 32 shift
// steps, then finds the leading digit, then emits one character per cycle into
// an output register while the receiver keeps taking them. A number holds the
// converter from the moment it is taken from the queue until its last character
// has gone into the output register.
// When the receiver stalls, the output register holds its character and the
// converter waits; the queue and the front stage then fill and req_chan.ready
// drops. Synchronous reset empties the queue and the front stage and returns the
// converter to idle; no response is pending after reset.
module signed_int_to_decimal_ascii #(
   parameter int QUEUE_DEPTH = sida_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   sida_req_if.sink    req_chan,
   sida_rsp_if.source  rsp_chan
);

   localparam int LVL_W = $clog2(QUEUE_DEPTH+1);

   // Front stage to queue.
   logic                push_valid;
   logic                push_ready;
   sida_pkg::entry_type push_entry;

   // Queue to converter.
   logic                pop_valid;
   logic                pop_ready;
   sida_pkg::entry_type pop_entry;

   logic [LVL_W-1:0]    queue_level;
   logic                back_busy;

   sida_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   sida_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .level      (queue_level)
   );

   sida_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .busy      (back_busy),
      .rsp_chan  (rsp_chan)
   );

`ifndef ASSERT_OFF
   // The queue never holds more entries than it has slots.
   assert property (@(posedge clock) disable iff (reset)
      queue_level <= LVL_W'(QUEUE_DEPTH))
      else $error("queue level exceeds its depth");

   // A handed-over entry is in the queue on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_ready) |=> (queue_level != '0))
      else $error("queue empty right after a push");

   // A character that is not the last one means the converter is still printing.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.last) |-> back_busy)
      else $error("converter went idle before the last character");

   // The converter takes a new entry only when it is idle, and then starts converting.
   assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> back_busy)
      else $error("converter did not start after taking an entry");
`endif

endmodule

// ===== verif/signed_int_to_decimal_ascii_tb.sv =====
module signed_int_to_decimal_ascii_tb;

   timeunit 1ns;
   timeprecision 1ps;

   // The block prints in base ten.
   localparam int unsigned RADIX = 10;
   // Cycles to keep watching after the last expected character, so that any
   // stray trailing character still shows up as a failure.
   localparam int DRAIN_TAIL = 60;
   // Length of the long receiver hold-off in the back-pressure test.
   localparam int HOLD_OFF_LEN = 400;

   // One expected character of the rendered text.
   typedef struct {
      logic [sida_pkg::CHAR_W-1:0] character;
      logic                        last;
   } text_char_type;

   // How the receiver paces its ready line.
   typedef enum int {
      RSP_ALWAYS,
      RSP_RANDOM,
      RSP_PERIODIC,
      RSP_SPARSE
   } rsp_pace_type;

   logic clock;
   logic reset;

   sida_req_if req_bus ();
   sida_rsp_if rsp_bus ();

   signed_int_to_decimal_ascii dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Characters still owed by the block, oldest at the front.
   text_char_type expected_text[$];
   int            mismatch_count = 0;
   rsp_pace_type  rsp_pace = RSP_ALWAYS;
   int            hold_off_cycles = 0;
   int            pace_phase = 0;

   // Free-running 100 MHz clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Every mismatch goes through here: one line each, and a running count.
   task automatic note_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   // Predicts the text of one accepted request. The sign is taken from the top
   // bit, and the magnitude is formed in 32 unsigned bits, so the most negative
   // value comes out as a full ten-digit magnitude rather than overflowing.
   // Digits are peeled off least significant first, then replayed in reverse so
   // the most significant digit goes out first. Zero yields a lone '0'.
   function automatic void render_decimal(input logic [sida_pkg::VALUE_W-1:0] bits);
      logic                         negative;
      logic [sida_pkg::VALUE_W-1:0] magnitude;
      logic [3:0]                   digit_rev [sida_pkg::DIGITS];
      int                           n_digits;
      int                           k;
      text_char_type                ch;
      negative  = bits[sida_pkg::VALUE_W-1];
      magnitude = negative ? (sida_pkg::VALUE_W'(0) - bits) : bits;
      n_digits  = 0;
      do begin
         digit_rev[n_digits] = 4'(magnitude % RADIX);
         magnitude           = magnitude / RADIX;
         n_digits++;
      end while (magnitude != 0 && n_digits < sida_pkg::DIGITS);
      if (negative) begin
         ch.character = sida_pkg::CH_MINUS;
         ch.last      = 1'b0;
         expected_text.push_back(ch);
      end
      for (k = n_digits - 1; k >= 0; k--) begin
         ch.character = sida_pkg::CH_ZERO + sida_pkg::CHAR_W'(digit_rev[k]);
         ch.last      = (k == 0);
         expected_text.push_back(ch);
      end
   endfunction

   // Request monitor: every request the block accepts is turned into the
   // characters it must produce. Sampling at the rising edge sees the values
   // that were stable through the edge.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         render_decimal(req_bus.value);
      end
   end

   // Response checker: each accepted character is compared with the oldest
   // prediction, one field at a time.
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_text.size() == 0) begin
            note_mismatch($sformatf("unexpected character %0d last %0b",
                                    rsp_bus.character, rsp_bus.last));
         end else begin
            want = expected_text.pop_front();
            if (rsp_bus.character !== want.character) begin
               note_mismatch($sformatf("character %0d, expected %0d",
                                       rsp_bus.character, want.character));
            end
            if (rsp_bus.last !== want.last) begin
               note_mismatch($sformatf("last %0b on character %0d, expected %0b",
                                       rsp_bus.last, want.character, want.last));
            end
         end
      end
   end

   // Receiver. A pending hold-off always wins and is counted down here, one
   // cycle per falling edge; otherwise the ready line follows the current pace.
   always @(negedge clock) begin
      pace_phase++;
      if (hold_off_cycles > 0) begin
         hold_off_cycles--;
         rsp_bus.ready <= 1'b0;
      end else begin
         case (rsp_pace)
            RSP_ALWAYS:   rsp_bus.ready <= 1'b1;
            RSP_RANDOM:   rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            RSP_PERIODIC: rsp_bus.ready <= ((pace_phase % 7) < 4);
            RSP_SPARSE:   rsp_bus.ready <= ($urandom_range(0, 4) == 0);
            default:      rsp_bus.ready <= 1'b1;
         endcase
      end
   end

   // Offers one request from the next falling edge and holds it until the
   // block takes it. The task returns right after the accepting rising edge,
   // so a following request simply replaces it at the next falling edge and
   // valid is never dropped and raised within one time step.
   task automatic send_value(input logic [sida_pkg::VALUE_W-1:0] v);
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Sender gap with valid low; n sets its length. The value bus carries junk meanwhile,
   // which the block must ignore.
   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         req_bus.value <= $urandom;
      end
   endtask

   // Random values spread over every text length: full-width noise, tiny
   // numbers, random bit lengths, powers of ten and their neighbors (where
   // the digit count changes), and values close to both ends of the range.
   function automatic logic [sida_pkg::VALUE_W-1:0] pick_value();
      logic [sida_pkg::VALUE_W-1:0] v;
      logic [sida_pkg::VALUE_W-1:0] p;
      int                           n;
      case ($urandom_range(0, 5))
         0: v = $urandom_range(0, 20);
         1: v = $urandom >> $urandom_range(0, 31);
         2: begin
            p = 1;
            n = $urandom_range(0, 9);
            repeat (n) p = p * RADIX;
            v = p + sida_pkg::VALUE_W'($urandom_range(0, 2)) - 1;
         end
         3: v = ($urandom_range(0, 1) == 1) ? (32'h8000_0000 + $urandom_range(0, 3))
                                            : (32'h7FFF_FFFF - $urandom_range(0, 3));
         default: v = $urandom;
      endcase
      // Negate half of the small and structured values as well.
      if ($urandom_range(0, 1) == 1 && v[sida_pkg::VALUE_W-1] == 1'b0) begin
         v = sida_pkg::VALUE_W'(0) - v;
      end
      return v;
   endfunction

   // Sends count random requests in bursts of random length. Roughly one gap
   // in four is skipped so that long back-to-back stretches occur as well.
   task automatic send_bursts(input int count, input int max_gap);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && sent < count) begin
            send_value(pick_value());
            burst--;
            sent++;
         end
         if ($urandom_range(0, 3) != 0) begin
            idle_cycles($urandom_range(1, max_gap));
         end
      end
   endtask

   // Edge values first: zero, one digit, digit-count boundaries in both signs,
   // both ends of the range (the most negative value has no positive partner in
   // 32 bits), and alternating bit patterns.
   task automatic test_directed();
      logic [sida_pkg::VALUE_W-1:0] cases [$];
      rsp_pace = RSP_ALWAYS;
      cases = {32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
               32'd999_999_999, 32'd1_000_000_000, -32'sd999_999_999,
               -32'sd1_000_000_000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1_234_567_890};
      foreach (cases[i]) begin
         send_value(cases[i]);
         if (i % 4 == 3) idle_cycles($urandom_range(1, 5));
      end
   endtask

   // Bulk random traffic against a receiver that drops ready at random.
   task automatic test_random_traffic();
      rsp_pace = RSP_RANDOM;
      send_bursts(200, 40);
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // requests back to back. The queue, the front stage and the output register
   // fill up, and req_bus.ready has to drop until the receiver comes back.
   task automatic test_output_hold_off();
      int i;
      rsp_pace        = RSP_RANDOM;
      hold_off_cycles = HOLD_OFF_LEN;
      for (i = 0; i < 30; i++) begin
         send_value(pick_value());
      end
   endtask

   // A slow receiver: first one that rarely takes a character, then a fixed
   // on/off rhythm, which lands stalls on varying digits of each number.
   task automatic test_slow_receiver();
      rsp_pace = RSP_SPARSE;
      send_bursts(50, 20);
      rsp_pace = RSP_PERIODIC;
      send_bursts(50, 20);
   endtask

   // A receiver that never stalls and a sender with only short gaps, so that
   // requests arrive while the converter is busy in every phase.
   task automatic test_fast_stream();
      rsp_pace = RSP_ALWAYS;
      send_bursts(80, 3);
   endtask

   // Run deadline, well beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_traffic();
      test_output_hold_off();
      test_slow_receiver();
      test_fast_stream();

      // Stop offering, wait for every owed character, then watch a little
      // longer for anything extra.
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== signed_int_to_decimal_ascii.f =====
src/sida_pkg.sv
src/sida_if.sv
src/sida_front.sv
src/sida_fifo.sv
src/sida_back.sv
src/signed_int_to_decimal_ascii.sv
verif/signed_int_to_decimal_ascii_tb.sv
